// ----- rtl/grid_path_count_turn_limit_macros.svh -----
// Assertion macros for the grid path counter.
// Needs a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef GRID_PATH_COUNT_TURN_LIMIT_MACROS_SVH
`define GRID_PATH_COUNT_TURN_LIMIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("grid path counter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("grid path counter: next-cycle check failed");

`endif

// ----- rtl/gpc_pkg.sv -----
// Shared constants for the grid path counter.
// No dependencies.
package gpc_pkg;

    localparam int GRID_SIZE_W = 7;
    localparam int MAX_TURNS_W = 2;
    localparam int TURN_W      = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;
    localparam int RESULT_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TURNS = 1'b1;

    localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RST = 7'd2;
    localparam logic [MAX_TURNS_W-1:0] MAX_TURNS_RST = 2'd3;

    localparam int DIR_DOWN  = 0;
    localparam int DIR_RIGHT = 1;

endpackage

// ----- rtl/grid_path_count_turn_limit.sv -----
// Turn-limited monotone path counter: one grid cell per cycle while the input is not
// stalled, one result per grid. The row store is read when a cell is accepted and written
// back in the next cycle, with forwarding for a back-to-back access to one column.
// A result passes stage one, stage two and the result queue before it shows on the output.
// Reset (synchronous) clears positions, pipeline and result queue and sets grid size 2,
// turn limit 3; the row store is not cleared and needs no clearing pass.
module grid_path_count_turn_limit #(
    parameter int GRID_MAX       = 64,
    parameter int TURN_LIMIT_MAX = 3,
    parameter int COUNT_WIDTH    = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gpc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gpc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_cell_blocked,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [gpc_pkg::RESULT_W-1:0]      o_path_count
);

`include "grid_path_count_turn_limit_macros.svh"

    localparam int TURN_SLOTS = TURN_LIMIT_MAX + 1;
    localparam int POS_W      = $clog2(GRID_MAX);
    localparam int CMP_W      = (POS_W + 1 > gpc_pkg::GRID_SIZE_W) ? POS_W + 1
                                                                   : gpc_pkg::GRID_SIZE_W;
    localparam int Q_DEPTH    = 4;
    localparam int QP_W       = $clog2(Q_DEPTH);
    localparam int QC_W       = QP_W + 1;

    typedef logic [TURN_SLOTS-1:0][1:0][COUNT_WIDTH-1:0] t_counts;
    localparam int ROW_W = $bits(t_counts);

    // Configuration registers.
    logic [gpc_pkg::GRID_SIZE_W-1:0] r_grid_size;
    logic [gpc_pkg::MAX_TURNS_W-1:0] r_max_turns;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= gpc_pkg::GRID_SIZE_RST;
            r_max_turns <= gpc_pkg::MAX_TURNS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gpc_pkg::CFG_GRID_SIZE: r_grid_size <= i_cfg_data[gpc_pkg::GRID_SIZE_W-1:0];
                gpc_pkg::CFG_MAX_TURNS: r_max_turns <= i_cfg_data[gpc_pkg::MAX_TURNS_W-1:0];
                default: ;
            endcase
        end
    end

    logic [CMP_W-1:0]           eff_size;
    logic [gpc_pkg::TURN_W-1:0] eff_turns;

    always_comb begin
        if (r_grid_size == '0) begin
            eff_size = CMP_W'(1);
        end else if (CMP_W'(r_grid_size) > CMP_W'(GRID_MAX)) begin
            eff_size = CMP_W'(GRID_MAX);
        end else begin
            eff_size = CMP_W'(r_grid_size);
        end
        if (gpc_pkg::TURN_W'(r_max_turns) > gpc_pkg::TURN_W'(TURN_LIMIT_MAX)) begin
            eff_turns = gpc_pkg::TURN_W'(TURN_LIMIT_MAX);
        end else begin
            eff_turns = gpc_pkg::TURN_W'(r_max_turns);
        end
    end

    // Position counters and input acceptance.
    logic [POS_W-1:0] r_row, n_row;
    logic [POS_W-1:0] r_col, n_col;
    logic             in_acc;
    logic             acc_last_col;
    logic             acc_last_row;
    logic             acc_last_cell;

    assign in_acc        = i_in_valid && !o_in_stall;
    assign acc_last_col  = (CMP_W'(r_col) + CMP_W'(1)) >= eff_size;
    assign acc_last_row  = (CMP_W'(r_row) + CMP_W'(1)) >= eff_size;
    assign acc_last_cell = acc_last_col && acc_last_row;

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (acc_last_cell) begin
            n_row = '0;
            n_col = '0;
        end else if (acc_last_col) begin
            n_row = r_row + POS_W'(1);
            n_col = '0;
        end else begin
            n_col = r_col + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_acc) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // Stage one: the row store entry arrives, the cell's counts are formed and written back.
    logic                       r_s1_valid;
    logic                       r_s1_last;
    logic                       r_s1_start;
    logic                       r_s1_blocked;
    logic                       r_s1_row_zero;
    logic                       r_s1_col_zero;
    logic                       r_s1_down_seed;
    logic                       r_s1_right_seed;
    logic [POS_W-1:0]           r_s1_col;
    logic [gpc_pkg::TURN_W-1:0] r_s1_turns;
    logic                       r_fwd_hit;
    t_counts                    r_fwd_data;
    t_counts                    r_left;
    t_counts                    s1_above;
    t_counts                    s1_cur;
    logic [ROW_W-1:0]           ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
            r_s1_last  <= in_acc && acc_last_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_start      <= (r_row == '0) && (r_col == '0);
            r_s1_blocked    <= i_cell_blocked;
            r_s1_row_zero   <= (r_row == '0);
            r_s1_col_zero   <= (r_col == '0);
            r_s1_down_seed  <= (r_row == POS_W'(1)) && (r_col == '0);
            r_s1_right_seed <= (r_row == '0) && (r_col == POS_W'(1));
            r_s1_col        <= r_col;
            r_s1_turns      <= eff_turns;
            r_fwd_hit       <= r_s1_valid && (r_s1_col == r_col);
        end
        if (r_s1_valid) begin
            r_fwd_data <= s1_cur;
            r_left     <= s1_cur;
        end
    end

    gpc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (GRID_MAX),
        .ADDR_W(POS_W)
    ) u_row_store (
        .i_clk  (i_clk),
        .i_we   (r_s1_valid),
        .i_waddr(r_s1_col),
        .i_wdata(s1_cur),
        .i_re   (in_acc),
        .i_raddr(r_col),
        .o_rdata(ram_rdata)
    );

    assign s1_above = r_fwd_hit ? r_fwd_data : t_counts'(ram_rdata);

    always_comb begin
        logic [COUNT_WIDTH-1:0] d;
        logic [COUNT_WIDTH-1:0] rt;
        s1_cur = '0;
        for (int k = 0; k < TURN_SLOTS; k++) begin
            d  = r_s1_row_zero ? '0 : s1_above[k][gpc_pkg::DIR_DOWN];
            rt = r_s1_col_zero ? '0 : r_left[k][gpc_pkg::DIR_RIGHT];
            if (k > 0) begin
                if (!r_s1_row_zero) begin
                    d = d + s1_above[(k > 0) ? k - 1 : 0][gpc_pkg::DIR_RIGHT];
                end
                if (!r_s1_col_zero) begin
                    rt = rt + r_left[(k > 0) ? k - 1 : 0][gpc_pkg::DIR_DOWN];
                end
            end else begin
                d  = d + COUNT_WIDTH'(r_s1_down_seed);
                rt = rt + COUNT_WIDTH'(r_s1_right_seed);
            end
            if (!r_s1_start && !r_s1_blocked && (gpc_pkg::TURN_W'(k) <= r_s1_turns)) begin
                s1_cur[k][gpc_pkg::DIR_DOWN]  = d;
                s1_cur[k][gpc_pkg::DIR_RIGHT] = rt;
            end
        end
    end

    // Stage two: per-budget sums of the last cell, then the total into the result queue.
    logic                                    r_s2_valid;
    logic [TURN_SLOTS-1:0][COUNT_WIDTH-1:0]  r_s2_pair;
    logic [COUNT_WIDTH-1:0]                  s2_sum;
    logic [63:0]                             s2_sum_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && r_s1_last) begin
            for (int k = 0; k < TURN_SLOTS; k++) begin
                r_s2_pair[k] <= s1_cur[k][gpc_pkg::DIR_DOWN] + s1_cur[k][gpc_pkg::DIR_RIGHT];
            end
        end
    end

    always_comb begin
        s2_sum = '0;
        for (int k = 0; k < TURN_SLOTS; k++) begin
            s2_sum = s2_sum + r_s2_pair[k];
        end
    end

    assign s2_sum_ext = 64'(s2_sum);

    // Result queue; its free space covers every result still in flight.
    logic [gpc_pkg::RESULT_W-1:0] r_q_data [Q_DEPTH];
    logic [QP_W-1:0]              r_q_wp;
    logic [QP_W-1:0]              r_q_rp;
    logic [QC_W-1:0]              r_q_cnt;
    logic                         q_push;
    logic                         q_pop;
    logic [QC_W:0]                q_occ;

    assign q_push = r_s2_valid;
    assign q_pop  = o_out_valid && !i_out_stall;
    assign q_occ  = (QC_W + 1)'(r_q_cnt) + (QC_W + 1)'(r_s1_valid && r_s1_last)
                  + (QC_W + 1)'(r_s2_valid) - (QC_W + 1)'(q_pop);

    assign o_in_stall   = q_occ > (QC_W + 1)'(Q_DEPTH - 1);
    assign o_out_valid  = r_q_cnt != '0;
    assign o_path_count = r_q_data[r_q_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wp  <= '0;
            r_q_rp  <= '0;
            r_q_cnt <= '0;
        end else begin
            if (q_push) begin
                r_q_wp <= r_q_wp + QP_W'(1);
            end
            if (q_pop) begin
                r_q_rp <= r_q_rp + QP_W'(1);
            end
            r_q_cnt <= r_q_cnt + QC_W'(q_push) - QC_W'(q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q_data[r_q_wp] <= s2_sum_ext[gpc_pkg::RESULT_W-1:0];
        end
    end

    `GPC_ASSERT_NEXT(a_rewind_after_last, in_acc && acc_last_cell, r_row == '0 && r_col == '0)
    `GPC_ASSERT_SAME(a_start_cell_zero, r_s1_valid && r_s1_start, s1_cur == '0)
    `GPC_ASSERT_SAME(a_queue_room, q_push && !q_pop, r_q_cnt < QC_W'(Q_DEPTH))

endmodule

// ----- rtl/gpc_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module gpc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sim/path_count_checker.sv -----
// Checker for the turn-limited grid path counter: follows the configuration port and both
// channels, keeps its own copy of the counting state and compares every result transaction.
// Depends on gpc_pkg for port widths, register indexes and direction slots.
`timescale 1ns / 100ps

module path_count_checker #(
    parameter int GRID_MAX       = 64,
    parameter int TURN_LIMIT_MAX = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gpc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gpc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic                              i_cell_blocked,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [gpc_pkg::RESULT_W-1:0]      i_path_count,
    output int                                o_fail_count,
    output int                                o_pending
);

    localparam int TURN_SLOTS = TURN_LIMIT_MAX + 1;

    logic [gpc_pkg::RESULT_W-1:0]    row_counts [GRID_MAX][TURN_SLOTS][2];
    logic [gpc_pkg::RESULT_W-1:0]    left_counts [TURN_SLOTS][2];
    logic [gpc_pkg::GRID_SIZE_W-1:0] size_reg;
    logic [gpc_pkg::MAX_TURNS_W-1:0] turns_reg;
    int unsigned                     row_pos;
    int unsigned                     col_pos;
    logic [gpc_pkg::RESULT_W-1:0]    expected_counts [$];
    logic [gpc_pkg::RESULT_W-1:0]    want;
    int                              mismatches = 0;

    function automatic void count_paths_at_cell(input logic blocked);
        int unsigned                  size_eff;
        int unsigned                  turn_eff;
        int unsigned                  r;
        int unsigned                  c;
        logic [gpc_pkg::RESULT_W-1:0] cur [TURN_SLOTS][2];
        logic [gpc_pkg::RESULT_W-1:0] down_sum;
        logic [gpc_pkg::RESULT_W-1:0] right_sum;
        logic [gpc_pkg::RESULT_W-1:0] total;
        size_eff = (size_reg == 0) ? 1 : ((size_reg > GRID_MAX) ? GRID_MAX : size_reg);
        turn_eff = (turns_reg > TURN_LIMIT_MAX) ? TURN_LIMIT_MAX : turns_reg;
        r = row_pos;
        c = (col_pos >= GRID_MAX) ? GRID_MAX - 1 : col_pos;
        for (int k = 0; k < TURN_SLOTS; k++) begin
            cur[k][gpc_pkg::DIR_DOWN]  = '0;
            cur[k][gpc_pkg::DIR_RIGHT] = '0;
        end
        if (!(r == 0 && c == 0) && !blocked) begin
            for (int k = 0; k <= turn_eff; k++) begin
                down_sum  = '0;
                right_sum = '0;
                if (r > 0) begin
                    down_sum = row_counts[c][k][gpc_pkg::DIR_DOWN];
                    if (k > 0) down_sum += row_counts[c][k-1][gpc_pkg::DIR_RIGHT];
                end
                if (c > 0) begin
                    right_sum = left_counts[k][gpc_pkg::DIR_RIGHT];
                    if (k > 0) right_sum += left_counts[k-1][gpc_pkg::DIR_DOWN];
                end
                if (k == 0 && r == 1 && c == 0) down_sum += 1;
                if (k == 0 && r == 0 && c == 1) right_sum += 1;
                cur[k][gpc_pkg::DIR_DOWN]  = down_sum;
                cur[k][gpc_pkg::DIR_RIGHT] = right_sum;
            end
        end
        for (int k = 0; k < TURN_SLOTS; k++) begin
            row_counts[c][k][gpc_pkg::DIR_DOWN]  = cur[k][gpc_pkg::DIR_DOWN];
            row_counts[c][k][gpc_pkg::DIR_RIGHT] = cur[k][gpc_pkg::DIR_RIGHT];
            left_counts[k][gpc_pkg::DIR_DOWN]    = cur[k][gpc_pkg::DIR_DOWN];
            left_counts[k][gpc_pkg::DIR_RIGHT]   = cur[k][gpc_pkg::DIR_RIGHT];
        end
        if (c + 1 >= size_eff && r + 1 >= size_eff) begin
            total = '0;
            for (int k = 0; k <= turn_eff; k++) begin
                total += cur[k][gpc_pkg::DIR_DOWN] + cur[k][gpc_pkg::DIR_RIGHT];
            end
            expected_counts.push_back(total);
            row_pos = 0;
            col_pos = 0;
        end else if (c + 1 >= size_eff) begin
            col_pos = 0;
            row_pos = r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            size_reg  = gpc_pkg::GRID_SIZE_RST;
            turns_reg = gpc_pkg::MAX_TURNS_RST;
            row_pos   = 0;
            col_pos   = 0;
            for (int k = 0; k < TURN_SLOTS; k++) begin
                left_counts[k][gpc_pkg::DIR_DOWN]  = '0;
                left_counts[k][gpc_pkg::DIR_RIGHT] = '0;
                for (int col = 0; col < GRID_MAX; col++) begin
                    row_counts[col][k][gpc_pkg::DIR_DOWN]  = '0;
                    row_counts[col][k][gpc_pkg::DIR_RIGHT] = '0;
                end
            end
            expected_counts.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == gpc_pkg::CFG_GRID_SIZE) begin
                    size_reg = i_cfg_data[gpc_pkg::GRID_SIZE_W-1:0];
                end else if (i_cfg_idx == gpc_pkg::CFG_MAX_TURNS) begin
                    turns_reg = i_cfg_data[gpc_pkg::MAX_TURNS_W-1:0];
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_counts.size() == 0) begin
                    $display("%0t: path count %0d arrived with no transaction expected",
                             $time, i_path_count);
                    mismatches++;
                end else begin
                    want = expected_counts.pop_front();
                    if (i_path_count !== want) begin
                        $display("%0t: path count expected %0d, got %0d",
                                 $time, want, i_path_count);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) count_paths_at_cell(i_cell_blocked);
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_counts.size();
    end

endmodule

// ----- sim/tb_top.sv -----
// Top of the testbench for the grid path counter: clock, reset, configuration writes and
// cell stimulus with random idling; the checker beside the block gives the failure count.
// Depends on gpc_pkg, grid_path_count_turn_limit and path_count_checker.
`timescale 1ns / 100ps

module tb_top;

    localparam int GRID_MAX       = 64;
    localparam int TURN_LIMIT_MAX = 3;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [gpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [gpc_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_in_valid;
    logic                           i_cell_blocked;
    logic                           i_out_stall;
    logic                           o_in_stall;
    logic                           o_out_valid;
    logic [gpc_pkg::RESULT_W-1:0]   o_path_count;
    int                             fail_count;
    int                             pending;

    bit                             gaps_on = 1'b0;
    int unsigned                    cur_size = 2;
    int unsigned                    cur_row = 0;
    int unsigned                    cur_col = 0;
    int unsigned                    sent_cells = 0;

    grid_path_count_turn_limit #(
        .GRID_MAX       (GRID_MAX),
        .TURN_LIMIT_MAX (TURN_LIMIT_MAX),
        .COUNT_WIDTH    (gpc_pkg::RESULT_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cell_blocked (i_cell_blocked),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_path_count   (o_path_count)
    );

    path_count_checker #(
        .GRID_MAX       (GRID_MAX),
        .TURN_LIMIT_MAX (TURN_LIMIT_MAX)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_cell_blocked (i_cell_blocked),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_path_count   (o_path_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("grid_path_count_turn_limit verification failed");
        $finish;
    end

    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (gaps_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(input logic [gpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gpc_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == gpc_pkg::CFG_GRID_SIZE)
            cur_size = (data == 0) ? 1 : ((data > GRID_MAX) ? GRID_MAX : data);
    endtask

    task automatic push_cell(input logic blocked);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cell_blocked <= blocked;
        do @(posedge i_clk); while (o_in_stall);
        sent_cells++;
        if (cur_col + 1 >= cur_size && cur_row + 1 >= cur_size) begin
            cur_row = 0;
            cur_col = 0;
        end else if (cur_col + 1 >= cur_size) begin
            cur_col = 0;
            cur_row++;
        end else begin
            cur_col++;
        end
    endtask

    // Finishes the grid in progress, or sends a whole one from the start cell.
    task automatic run_grid(input int unsigned density);
        do push_cell($urandom_range(0, 15) < density); while (cur_row != 0 || cur_col != 0);
    endtask

    task automatic pause_until_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (6) @(posedge i_clk);
    endtask

    initial begin
        logic [gpc_pkg::CFG_DATA_W-1:0] cfg_value;
        int unsigned                    pick;
        int                             waited;

        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= gpc_pkg::CFG_GRID_SIZE;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_cell_blocked <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: a 2x2 grid with every turn budget allowed.
        push_cell(1'b0); push_cell(1'b0); push_cell(1'b0); push_cell(1'b0);
        // The start cell's blocked bit must be ignored.
        push_cell(1'b1); push_cell(1'b0); push_cell(1'b0); push_cell(1'b0);
        // Both neighbours of the start blocked, so nothing reaches the end.
        push_cell(1'b0); push_cell(1'b1); push_cell(1'b1); push_cell(1'b0);

        pause_until_idle();
        write_reg(gpc_pkg::CFG_GRID_SIZE, 7'd1);
        push_cell(1'b0);
        push_cell(1'b1);
        pause_until_idle();
        write_reg(gpc_pkg::CFG_GRID_SIZE, 7'd0);
        push_cell(1'b0);

        // With no turns allowed a square grid larger than one cell has no path.
        pause_until_idle();
        write_reg(gpc_pkg::CFG_GRID_SIZE, 7'd3);
        write_reg(gpc_pkg::CFG_MAX_TURNS, 7'h04);
        repeat (9) push_cell(1'b0);

        // Largest grid, reached through saturation of an all-ones size, then shrunk
        // mid-grid so that the next cell is past the last column, in the last row.
        pause_until_idle();
        write_reg(gpc_pkg::CFG_GRID_SIZE, 7'h7F);
        write_reg(gpc_pkg::CFG_MAX_TURNS, 7'h7F);
        repeat (64 + 3) push_cell($urandom_range(0, 15) < 1);
        pause_until_idle();
        write_reg(gpc_pkg::CFG_GRID_SIZE, 7'd2);
        run_grid(0);

        pause_until_idle();
        write_reg(gpc_pkg::CFG_GRID_SIZE, 7'd4);
        while (sent_cells < 360) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1: begin
                    pause_until_idle();
                    pick = $urandom_range(0, 15);
                    if (pick == 0) cfg_value = 7'd0;
                    else if (pick == 1) cfg_value = 7'd1;
                    else if (pick == 2)
                        cfg_value = gpc_pkg::CFG_DATA_W'($urandom_range(9, 11));
                    else cfg_value = gpc_pkg::CFG_DATA_W'($urandom_range(2, 8));
                    write_reg(gpc_pkg::CFG_GRID_SIZE, cfg_value);
                end
                2: begin
                    pause_until_idle();
                    cfg_value = gpc_pkg::CFG_DATA_W'($urandom);
                    write_reg(gpc_pkg::CFG_MAX_TURNS, cfg_value);
                end
                3: begin
                    if (cur_size > 1) begin
                        repeat ($urandom_range(1, cur_size * cur_size - 1))
                            push_cell($urandom_range(0, 15) < 2);
                        pause_until_idle();
                        if ($urandom_range(0, 1) == 0) begin
                            cfg_value = gpc_pkg::CFG_DATA_W'($urandom_range(1, cur_size));
                            write_reg(gpc_pkg::CFG_GRID_SIZE, cfg_value);
                        end else begin
                            cfg_value = gpc_pkg::CFG_DATA_W'($urandom);
                            write_reg(gpc_pkg::CFG_MAX_TURNS, cfg_value);
                        end
                        run_grid($urandom_range(0, 4));
                    end
                end
                default: run_grid($urandom_range(0, 5));
            endcase
        end

        gaps_on = 1'b0;
        pause_until_idle();
        write_reg(gpc_pkg::CFG_GRID_SIZE, 7'd3);
        repeat (4) run_grid($urandom_range(0, 3));

        i_in_valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending != 0 && waited < 5000);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("grid_path_count_turn_limit verification clean");
        else
            $display("grid_path_count_turn_limit verification failed");
        $finish;
    end

endmodule
